### rtl/core/dcws_pkg.sv
// ----------------------------------------------------------------------------
// dcws_pkg
// Shared types, constants and helpers for the duty-cycle wake scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package dcws_pkg;

  localparam int unsigned NUM_SLOTS    = 144;
  localparam int unsigned SLOT_W       = 8;
  localparam int unsigned RUN_W        = 8;
  localparam int unsigned SCHED_W      = 48;
  localparam int unsigned IDLE_W       = 17;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);
  localparam logic [RUN_W-1:0]  MAX_RUN   = RUN_W'(NUM_SLOTS);

  // op codes carried on in_tuser
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_LOAD    = 2'd1;
  localparam logic [1:0] OP_REFRESH = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_SCHED_LOW  = 2'd0;
  localparam logic [1:0] REG_SCHED_MID  = 2'd1;
  localparam logic [1:0] REG_SCHED_HIGH = 2'd2;
  localparam logic [1:0] REG_NET_ENABLE = 2'd3;

  typedef struct packed {
    logic              start;
    logic [SLOT_W-1:0] first_slot;
  } scan_cmd_t;

  typedef struct packed {
    logic             done;
    logic [RUN_W-1:0] run;
  } scan_status_t;

  // minute / 10 for 0..63 by reciprocal multiply
  function automatic logic [2:0] div10(input logic [5:0] m);
    logic [13:0] prod;
    prod = 14'(m) * 14'd205;
    return prod[13:11];
  endfunction

  // next slot index with wrap
  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + SLOT_W'(1);
  endfunction

endpackage

`default_nettype wire

### rtl/core/dcws_slot_scan.sv
// ----------------------------------------------------------------------------
// dcws_slot_scan
// Walks the schedule one slot per cycle from a start slot and counts the run
// of set slots, wrapping, at most one full lap.
// ----------------------------------------------------------------------------
`default_nettype none

module dcws_slot_scan
  import dcws_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic [3*SCHED_W-1:0]     sched,
  input  wire scan_cmd_t                cmd,
  output scan_status_t                  status
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic [RUN_W-1:0]  run_r, run_nxt;
  logic [RUN_W-1:0]  run_inc;

  assign run_inc = run_r + RUN_W'(1);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    idx_nxt  = idx_r;
    run_nxt  = run_r;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      idx_nxt  = cmd.first_slot;
      run_nxt  = '0;
    end else if (busy_r) begin
      if (!sched[idx_r]) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        run_nxt = run_inc;
        idx_nxt = slot_inc(idx_r);
        // full lap of set slots
        if (run_inc == MAX_RUN) begin
          busy_nxt = 1'b0;
          done_nxt = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    idx_r <= idx_nxt;
    run_r <= run_nxt;
  end

  assign status.done = done_r;
  assign status.run  = run_r;

endmodule

`default_nettype wire

### rtl/core/duty_cycle_wake_scheduler_top.sv
// ----------------------------------------------------------------------------
// duty_cycle_wake_scheduler_top
// Time-of-day clock with a 144-slot ten-minute wake schedule.
// ----------------------------------------------------------------------------
// Each input transfer (tick, time load or active-flag refresh, selected by
// in_tuser) produces one result transfer with the time, day count, active flag
// and idle seconds. An item passes through ST_START and ST_CALC; when the node
// is active it also waits in ST_SCAN while the slot scanner counts the run of
// set slots following the current one, ending early after a full lap of 144.
// The slot scanner checks one schedule bit per cycle, and a result that waits
// on out_tready adds its stall to the item. in_tready is low while an item is
// in progress. The user must write the schedule registers and net enable
// through the cfg port only while the block is idle; the block itself does not
// enforce this. Net enable resets to 1.
`default_nettype none

module duty_cycle_wake_scheduler_top
  import dcws_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // load_hour[4:0], load_minute[10:5], load_second[16:11]
  input  wire logic [1:0]  in_tuser,   // op[1:0]

  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // hour_now[4:0], minute_now[10:5], second_now[16:11],
                                       // day_total[32:17], is_active[33], idle_seconds[50:34]

  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [47:0] cfg_wdata
);

  typedef enum logic [1:0] {ST_IDLE, ST_START, ST_SCAN, ST_CALC} state_t;

  state_t              state_r, state_nxt;
  logic [4:0]          hour_r, hour_nxt;
  logic [5:0]          minute_r, minute_nxt;
  logic [5:0]          second_r, second_nxt;
  logic [15:0]         day_r, day_nxt;
  logic                active_r, active_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [55:0]         out_data_r, out_data_nxt;

  logic [SCHED_W-1:0]  sched_low_r, sched_mid_r, sched_high_r;
  logic                net_en_r;
  logic [3*SCHED_W-1:0] sched;

  scan_cmd_t           scan_cmd;
  scan_status_t        scan_status;

  logic                in_xfer;
  logic [1:0]          op;
  logic [6:0]          sec_inc, min_inc;
  logic [5:0]          hour_inc;
  logic [2:0]          min_tens;
  logic [3:0]          min_units;
  logic [SLOT_W-1:0]   slot_raw, cur_slot;
  logic [10:0]         slot_mins;
  logic [IDLE_W-1:0]   idle_base, idle_val;

  assign sched     = {sched_high_r, sched_mid_r, sched_low_r};
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign op        = in_tuser;

  // current slot = (hour*6 + minute/10) mod 144
  assign min_tens  = div10(minute_r);
  assign min_units = 4'(minute_r - 6'(min_tens) * 6'd10);
  assign slot_raw  = (SLOT_W'(hour_r) << 2) + (SLOT_W'(hour_r) << 1) + SLOT_W'(min_tens);
  assign cur_slot  = (slot_raw >= SLOT_W'(NUM_SLOTS)) ? slot_raw - SLOT_W'(NUM_SLOTS) : slot_raw;

  // idle = (10*run + 9 - minute%10)*60 + 60 - second, clamped at zero
  assign slot_mins = (11'(scan_status.run) << 3) + (11'(scan_status.run) << 1)
                     + 11'd9 - 11'(min_units);
  assign idle_base = (IDLE_W'(slot_mins) << 6) - (IDLE_W'(slot_mins) << 2) + IDLE_W'(60);
  assign idle_val  = (idle_base < IDLE_W'(second_r)) ? '0 : idle_base - IDLE_W'(second_r);

  assign sec_inc  = 7'(second_r) + 7'd1;

  always_comb begin
    state_nxt     = state_r;
    hour_nxt      = hour_r;
    minute_nxt    = minute_r;
    second_nxt    = second_r;
    day_nxt       = day_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    scan_cmd      = '{start: 1'b0, first_slot: slot_inc(cur_slot)};
    min_inc       = 7'(minute_r);
    hour_inc      = 6'(hour_r);

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = ST_START;
          case (op)
            OP_TICK: begin
              second_nxt = sec_inc[5:0];
              if (sec_inc >= 7'd60) begin
                second_nxt = '0;
                min_inc    = 7'(minute_r) + 7'd1;
              end
              minute_nxt = min_inc[5:0];
              if (min_inc >= 7'd60) begin
                minute_nxt = '0;
                hour_inc   = 6'(hour_r) + 6'd1;
              end
              hour_nxt = hour_inc[4:0];
              if (hour_inc >= 6'd24) begin
                hour_nxt = '0;
                day_nxt  = day_r + 16'd1;
              end
            end
            OP_LOAD: begin
              hour_nxt   = in_tdata[4:0];
              minute_nxt = in_tdata[10:5];
              second_nxt = in_tdata[16:11];
            end
            OP_REFRESH: begin
              active_nxt = net_en_r && sched[cur_slot];
            end
            default: ;
          endcase
        end
      end
      ST_START: begin
        if (active_r) begin
          scan_cmd.start = 1'b1;
          state_nxt      = ST_SCAN;
        end else begin
          state_nxt = ST_CALC;
        end
      end
      ST_SCAN: begin
        if (scan_status.done) begin
          state_nxt = ST_CALC;
        end
      end
      ST_CALC: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {5'd0,
                           (active_r ? idle_val : IDLE_W'(0)),
                           active_r, day_r, second_r, minute_r, hour_r};
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      hour_r       <= '0;
      minute_r     <= '0;
      second_r     <= '0;
      day_r        <= '0;
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
      sched_low_r  <= '0;
      sched_mid_r  <= '0;
      sched_high_r <= '0;
      net_en_r     <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      hour_r      <= hour_nxt;
      minute_r    <= minute_nxt;
      second_r    <= second_nxt;
      day_r       <= day_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_SCHED_LOW:  sched_low_r  <= cfg_wdata;
          REG_SCHED_MID:  sched_mid_r  <= cfg_wdata;
          REG_SCHED_HIGH: sched_high_r <= cfg_wdata;
          REG_NET_ENABLE: net_en_r     <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
    out_data_r <= out_data_nxt;
  end

  dcws_slot_scan u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .sched  (sched),
    .cmd    (scan_cmd),
    .status (scan_status)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // idle seconds are only reported while the node is awake
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[33] || out_tdata[50:34] == '0))
    else $error("idle seconds nonzero while inactive");

  // no new transfer accepted right after one
  assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_tready)
    else $error("input accepted while item in progress");

  // the scanner reports only while its result is awaited
  assert property (@(posedge clk) disable iff (!rst_n)
    scan_status.done |-> (state_r == ST_SCAN && scan_status.run <= MAX_RUN))
    else $error("unexpected scan completion");

  // time fields only move on an accepted item
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |=> $stable(day_r) && $stable(second_r))
    else $error("time changed mid item");

endmodule

`default_nettype wire
